[design/lkc_pkg.sv]
// Shared types and constants for the keyed LRU cache.
`timescale 1ns / 1ps
package lkc_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned OCC_W    = 8;
  localparam int unsigned DEF_CAPACITY = 128;

  localparam int unsigned IN_TDATA_W  = 160;
  localparam int unsigned OUT_TDATA_W = 144;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One cache entry as it moves along the row.
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key_high;
    logic [KEY_W-1:0]    key_low;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Broadcast commands to every cell.
  typedef struct packed {
    logic compare;   // latch the match flag against the request key
    logic promote;   // matched entry moves to the head, younger ones age
    logic insert;    // whole row shifts toward the tail, new entry at head
    logic drop;      // matched entry leaves, older ones move up
    logic clear;     // invalidate all
  } cell_ctl_t;

endpackage

[design/lru_keyed_cache.sv]
// Top level of the fully associative 128-bit keyed cache with LRU replacement.
`timescale 1ns / 1ps
// Entries sit in a row of cells ordered by recency: the head cell is the most
// recent, the last valid cell the least recent. In the accept cycle of a
// request every cell latches a key match flag; then, in ST_EXEC, entries
// shift between neighbors to promote, insert, remove or clear and the result
// register loads. A new request is accepted while the previous result waits;
// ST_EXEC holds until the result register is free. The match and payload
// selection ripple along the row, so their depth grows with CAPACITY. Valid
// flags clear at reset; no clearing pass is needed.
module lru_keyed_cache #(
  parameter int unsigned CAPACITY = lkc_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [63:0] key_high, [127:64] key_low, [159:128] payload_in
  input  logic [lkc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] op
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] hit, [32:1] payload_out, [33] evicted, [41:34] occupancy,
  // [73:42] hit_total, [105:74] miss_total, [137:106] eviction_total
  output logic [lkc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import lkc_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [KEY_W-1:0]    key_high_r, key_low_r;
  logic [HANDLE_W-1:0] pay_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]    hits_r, hits_nxt, miss_r, miss_nxt, evc_r, evc_nxt;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  cell_ctl_t ctl;
  entry_t    ent   [CAPACITY];
  entry_t    head;
  entry_t    tail;
  logic      pre   [CAPACITY+1];
  logic      suf   [CAPACITY+1];
  logic [HANDLE_W-1:0] hsel [CAPACITY+1];

  logic accept, fire, any_hit, full;
  logic res_hit, res_ev;
  logic [HANDLE_W-1:0] res_pay;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign fire      = (state_r == ST_EXEC) & (~out_valid_r | out_tready);
  assign any_hit   = pre[CAPACITY];
  assign full      = (count_r == CW'(CAPACITY));

  assign pre[0]        = 1'b0;
  assign suf[CAPACITY] = 1'b0;
  assign hsel[0]       = '0;

  always_comb begin
    head.valid    = 1'b1;
    head.key_high = key_high_r;
    head.key_low  = key_low_r;
    head.handle   = (op_r == OP_STORE) ? pay_r : hsel[CAPACITY];
    tail          = '0;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      lkc_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmp_high    (in_tdata[KEY_W-1:0]),
        .cmp_low     (in_tdata[2*KEY_W-1:KEY_W]),
        .left_entry  ((g == 0) ? head : ent[(g == 0) ? 0 : g-1]),
        .right_entry ((g == CAPACITY-1) ? tail : ent[(g == CAPACITY-1) ? g : g+1]),
        .pre_in      (pre[g]),
        .suf_in      (suf[g+1]),
        .hsel_in     (hsel[g]),
        .entry       (ent[g]),
        .pre_out     (pre[g+1]),
        .suf_out     (suf[g]),
        .hsel_out    (hsel[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.compare = accept;
    count_nxt   = count_r;
    hits_nxt    = hits_r;
    miss_nxt    = miss_r;
    evc_nxt     = evc_r;
    res_hit     = 1'b0;
    res_pay     = '0;
    res_ev      = 1'b0;
    if (fire) begin
      unique case (op_r)
        OP_LOOKUP: begin
          if (any_hit) begin
            ctl.promote = 1'b1;
            res_hit     = 1'b1;
            res_pay     = hsel[CAPACITY];
            hits_nxt    = (&hits_r) ? hits_r : hits_r + 1'b1;
          end else begin
            miss_nxt = (&miss_r) ? miss_r : miss_r + 1'b1;
          end
        end
        OP_STORE: begin
          if (any_hit) begin
            ctl.promote = 1'b1;
          end else begin
            ctl.insert = 1'b1;
            if (full) begin
              res_ev  = 1'b1;
              evc_nxt = (&evc_r) ? evc_r : evc_r + 1'b1;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (any_hit) begin
            ctl.drop  = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_CLEAR: begin
          ctl.clear = 1'b1;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data_nxt = {6'd0, evc_nxt, miss_nxt, hits_nxt, OCC_W'(count_nxt), res_ev,
                    res_pay, res_hit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      evc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hits_r  <= hits_nxt;
      miss_r  <= miss_nxt;
      evc_r   <= evc_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the request and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(in_tuser);
      key_high_r <= in_tdata[KEY_W-1:0];
      key_low_r  <= in_tdata[2*KEY_W-1:KEY_W];
      pay_r      <= in_tdata[2*KEY_W+HANDLE_W-1:2*KEY_W];
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[design/lkc_cell.sv]
// One position of the recency-ordered entry row: storage, key compare, shift.
`timescale 1ns / 1ps
module lkc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkc_pkg::cell_ctl_t            ctl,
  input  logic [lkc_pkg::KEY_W-1:0]     cmp_high,
  input  logic [lkc_pkg::KEY_W-1:0]     cmp_low,
  input  lkc_pkg::entry_t               left_entry,
  input  lkc_pkg::entry_t               right_entry,
  input  logic                          pre_in,
  input  logic                          suf_in,
  input  logic [lkc_pkg::HANDLE_W-1:0]  hsel_in,
  output lkc_pkg::entry_t               entry,
  output logic                          pre_out,
  output logic                          suf_out,
  output logic [lkc_pkg::HANDLE_W-1:0]  hsel_out
);
  import lkc_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t data_r, data_nxt;
  logic   match_r;
  logic   take_left, take_right;

  // Match chains: pre marks a match at or before this cell, suf at or after.
  assign pre_out  = pre_in | match_r;
  assign suf_out  = suf_in | match_r;
  assign hsel_out = hsel_in | (match_r ? data_r.handle : '0);

  assign take_left  = ctl.insert | (ctl.promote & suf_out);
  assign take_right = ctl.drop & pre_out;

  always_comb begin
    entry       = data_r;
    entry.valid = valid_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (take_left) begin
      valid_nxt = left_entry.valid;
      data_nxt  = left_entry;
    end else if (take_right) begin
      valid_nxt = right_entry.valid;
      data_nxt  = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.compare) begin
        match_r <= valid_r && data_r.key_high == cmp_high && data_r.key_low == cmp_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
